/* sv/fir_filter_circular_assert.svh */
// assertion macros shared by the fir filter rtl
`ifndef FIR_FILTER_CIRCULAR_ASSERT_SVH
`define FIR_FILTER_CIRCULAR_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define FFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define FFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/ffc_pkg.sv */
// shared types and constants of the fir filter
package ffc_pkg;

	localparam int COEFF_W        = 16;
	localparam int FRAC_BITS      = 14;
	localparam int COEFF_PER_WORD = 4;
	localparam int TAP_CNT_W      = 4;
	localparam int SLOT_W         = 3;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 64;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_LOW   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_HIGH  = 2'd2;

	localparam logic [TAP_CNT_W-1:0]  TAP_COUNT_RESET  = 4'd1;
	localparam logic [APB_DATA_W-1:0] COEFF_LOW_RESET  = 64'd16384;
	localparam logic [APB_DATA_W-1:0] COEFF_HIGH_RESET = 64'd0;

	// per-item control seen by every tap cell
	typedef struct packed {
		logic [SLOT_W-1:0]    start;
		logic [TAP_CNT_W-1:0] taps;
	} tap_ctl_t;

endpackage

/* sv/fir_filter_circular.sv */
// top level of the circular-buffer direct-form fir filter
// Direct-form FIR filter over a circular delay line of up to MAX_TAPS signed samples. Each
// accepted sample is written into the slot the write pointer names (wrapped to zero when the
// pointer lies at or past the tap count), the pointer advances modulo the tap count, and the
// result is the sum over the tap_count newest samples with coefficient 0 on the oldest and
// coefficient tap_count-1 on the newest. Coefficients are signed Q2.14, four to a 64-bit
// register (tap 0 / tap 4 in bits 15:0), and are expected to be normalized by software. The
// sum is rounded half up and saturated to SAMPLE_WIDTH bits; saturated flags a clamp. A tap
// count of zero acts as one tap and one above MAX_TAPS acts as MAX_TAPS; the delay line is
// not cleared when the tap count changes. Registers on the APB port: tap_count at 0x00,
// coeff_word_low at 0x08, coeff_word_high at 0x10; write them only while no transfer is in
// flight. Each sample lives in its own tap cell; the products are formed in every cell at
// once and the partial sum ripples one cell per cycle down the chain. A new sample is taken
// only after the previous sum has been captured into the output register, and that capture
// waits while the output register still holds an untaken result. A finished result waits
// in the output register while the next sample is taken.
`include "fir_filter_circular_assert.svh"

module fir_filter_circular #(
	parameter int MAX_TAPS     = 8,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ffc_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [ffc_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ffc_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	// sample channel
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
	// result channel
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      filtered_out,
	output logic                                saturated
);
	import ffc_pkg::*;

	localparam int ACC_W = SAMPLE_WIDTH + COEFF_W + 1 + $clog2(MAX_TAPS);
	localparam int CNT_W = $clog2(MAX_TAPS + 2);
	// count at which the chain output is complete
	localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(MAX_TAPS + 1);
	localparam logic [TAP_CNT_W-1:0] TAPS_MAX = TAP_CNT_W'(MAX_TAPS);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [TAP_CNT_W-1:0]            tap_count_q;
	logic [APB_DATA_W-1:0]           coeff_low_q;
	logic [APB_DATA_W-1:0]           coeff_high_q;
	logic [SLOT_W-1:0]               write_slot_q;
	logic                            result_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  filtered_q;
	logic                            saturated_q;

	logic                            cfg_wr;
	logic [REG_IDX_W-1:0]            reg_idx;
	logic [TAP_CNT_W-1:0]            taps_eff;
	logic [TAP_CNT_W-1:0]            wslot;
	logic [TAP_CNT_W-1:0]            nslot;
	logic                            in_xfer;
	logic                            capture;
	tap_ctl_t                        ctl;
	logic signed [COEFF_W-1:0]       coeffs [MAX_TAPS];
	logic signed [ACC_W-1:0]         psum [MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0]  rs_value;
	logic                            rs_sat;

	// ---------------- configuration registers ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= TAP_COUNT_RESET;
			coeff_low_q  <= COEFF_LOW_RESET;
			coeff_high_q <= COEFF_HIGH_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TAP_COUNT:  tap_count_q  <= pwdata[TAP_CNT_W-1:0];
				REG_COEFF_LOW:  coeff_low_q  <= pwdata;
				REG_COEFF_HIGH: coeff_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TAP_COUNT:  prdata = APB_DATA_W'(tap_count_q);
			REG_COEFF_LOW:  prdata = coeff_low_q;
			REG_COEFF_HIGH: prdata = coeff_high_q;
			default:        prdata = '0;
		endcase
	end

	// unpack coefficient words, tap 0 and tap 4 in the lowest field of their words
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_coef
		if (k < COEFF_PER_WORD) begin : g_low
			assign coeffs[k] = coeff_low_q[COEFF_W*k +: COEFF_W];
		end else begin : g_high
			assign coeffs[k] = coeff_high_q[COEFF_W*(k-COEFF_PER_WORD) +: COEFF_W];
		end
	end

	// ---------------- write pointer ----------------
	// zero acts as one tap, anything above the cell count as all cells
	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = TAP_CNT_W'(1);
		end else if (tap_count_q > TAPS_MAX) begin
			taps_eff = TAPS_MAX;
		end else begin
			taps_eff = tap_count_q;
		end
		// pointer past the tap count after a shrink wraps before the write
		wslot = (TAP_CNT_W'(write_slot_q) >= taps_eff) ? '0 : TAP_CNT_W'(write_slot_q);
		nslot = wslot + TAP_CNT_W'(1);
		if (nslot >= taps_eff) begin
			nslot = '0;
		end
	end

	assign in_xfer = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
		end else if (in_xfer) begin
			write_slot_q <= nslot[SLOT_W-1:0];
		end
	end

	// after the write the pointer names the oldest sample
	assign ctl.start = write_slot_q;
	assign ctl.taps  = taps_eff;

	// ---------------- tap cell chain ----------------
	for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
		logic                    load;
		logic signed [ACC_W-1:0] chain_in;

		assign load = in_xfer && (wslot == TAP_CNT_W'(j));

		if (j == 0) begin : g_head
			assign chain_in = '0;
		end else begin : g_link
			assign chain_in = psum[j-1];
		end

		ffc_tap_cell #(
			.MAX_TAPS     (MAX_TAPS),
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.ACC_W        (ACC_W),
			.CELL_IDX     (j)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (load),
			.sample_in (sample_in),
			.coeffs    (coeffs),
			.ctl       (ctl),
			.psum_in   (chain_in),
			.psum_out  (psum[j])
		);
	end

	ffc_round_sat #(
		.ACC_W        (ACC_W),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_round_sat (
		.acc   (psum[MAX_TAPS-1]),
		.value (rs_value),
		.sat   (rs_sat)
	);

	// ---------------- sequencing ----------------
	// result lands in the output register once the chain has settled and the slot is free
	assign sample_ready = (state_q == ST_IDLE);
	assign capture      = (state_q == ST_RUN) && (cnt_q == CNT_DONE)
	                      && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (cnt_q != CNT_DONE) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (capture) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (capture) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			filtered_q  <= rs_value;
			saturated_q <= rs_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign filtered_out = filtered_q;
	assign saturated    = saturated_q;

	// ---------------- checks ----------------
	`FFC_ASSERT_NXT(a_start_run, clk, arst_n, in_xfer, (state_q == ST_RUN) && (cnt_q == '0), "sample transfer did not start a run")
	`FFC_ASSERT_IMP(a_result_src, clk, arst_n, $rose(result_valid_q), ($past(state_q) == ST_RUN) && ($past(cnt_q) == CNT_DONE), "result shown before chain settled")
	`FFC_ASSERT_IMP(a_cnt_range, clk, arst_n, state_q == ST_RUN, cnt_q <= CNT_DONE, "run counter out of range")

endmodule

/* sv/ffc_tap_cell.sv */
// one tap cell: delay line slot, coefficient select, multiply and partial sum
module ffc_tap_cell #(
	parameter int MAX_TAPS     = 8,
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_W        = 36,
	parameter int CELL_IDX     = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  logic signed [SAMPLE_WIDTH-1:0]         sample_in,
	input  logic signed [ffc_pkg::COEFF_W-1:0]     coeffs [MAX_TAPS],
	input  ffc_pkg::tap_ctl_t                      ctl,
	input  logic signed [ACC_W-1:0]                psum_in,
	output logic signed [ACC_W-1:0]                psum_out
);
	import ffc_pkg::*;

	localparam int IDX_W  = $clog2(MAX_TAPS);
	localparam int PROD_W = SAMPLE_WIDTH + COEFF_W;
	localparam logic [TAP_CNT_W-1:0] MY_IDX = TAP_CNT_W'(CELL_IDX);

	logic signed [SAMPLE_WIDTH-1:0] delay_q;
	logic signed [PROD_W-1:0]       prod_d;
	logic signed [PROD_W-1:0]       prod_q;
	logic signed [ACC_W-1:0]        psum_q;
	logic [TAP_CNT_W-1:0]           start_ext;
	logic [TAP_CNT_W-1:0]           coef_idx;
	logic signed [COEFF_W-1:0]      coef;
	logic                           active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
		end else if (load) begin
			delay_q <= sample_in;
		end
	end

	// coefficient index = distance of this slot from the oldest sample, modulo taps
	always_comb begin
		start_ext = TAP_CNT_W'(ctl.start);
		active    = MY_IDX < ctl.taps;
		if (MY_IDX >= start_ext) begin
			coef_idx = MY_IDX - start_ext;
		end else begin
			coef_idx = MY_IDX + ctl.taps - start_ext;
		end
		coef = coeffs[coef_idx[IDX_W-1:0]];
	end

	assign prod_d = delay_q * coef;

	always_ff @(posedge clk) begin
		prod_q <= active ? prod_d : '0;
		psum_q <= psum_in + ACC_W'(prod_q);
	end

	assign psum_out = psum_q;

endmodule

/* sv/ffc_round_sat.sv */
// round half up and saturate the accumulated sum to the sample width
module ffc_round_sat #(
	parameter int ACC_W        = 36,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic signed [ACC_W-1:0]        acc,
	output logic signed [SAMPLE_WIDTH-1:0] value,
	output logic                           sat
);
	import ffc_pkg::*;

	localparam int Y_W = ACC_W - FRAC_BITS;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2 ** (FRAC_BITS - 1));
	localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic signed [ACC_W-1:0]  rnd;
	logic [Y_W-1:0]           y;
	logic [Y_W-SAMPLE_WIDTH:0] hi;

	always_comb begin
		rnd = acc + HALF;
		y   = rnd[ACC_W-1:FRAC_BITS];
		hi  = y[Y_W-1:SAMPLE_WIDTH-1];
		sat = !((&hi) || !(|hi));
		if (sat) begin
			value = y[Y_W-1] ? S_MIN : S_MAX;
		end else begin
			value = y[SAMPLE_WIDTH-1:0];
		end
	end

endmodule
